/* hw/rtl/escu_pkg.sv */
// ----------------------------------------------------------------------------
// escu_pkg
// Shared types and character codes for the backslash unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package escu_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] count_t;
  typedef logic [20:0] code_t;

  // escape introducer and escape letters
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_U      = 8'h75;
  localparam byte_t CH_X      = 8'h78;
  localparam byte_t CH_B      = 8'h62;
  localparam byte_t CH_T      = 8'h74;
  localparam byte_t CH_N      = 8'h6E;
  localparam byte_t CH_R      = 8'h72;
  localparam byte_t CH_F      = 8'h66;
  localparam byte_t CH_S      = 8'h73;

  // bytes that the simple escapes stand for
  localparam byte_t OUT_BS    = 8'h08;
  localparam byte_t OUT_TAB   = 8'h09;
  localparam byte_t OUT_LF    = 8'h0A;
  localparam byte_t OUT_CR    = 8'h0D;
  localparam byte_t OUT_FF    = 8'h0C;
  localparam byte_t OUT_SPACE = 8'h20;

  // digit counts and the bytes that must follow the letter
  localparam logic [2:0] U_DIGITS = 3'd4;
  localparam logic [2:0] X_DIGITS = 3'd2;
  localparam count_t     U_MIN_AFTER = 16'd4;
  localparam count_t     X_MIN_AFTER = 16'd2;

  // code point ranges
  localparam code_t SURR_HIGH_BASE = 21'h00D800;
  localparam code_t SURR_LOW_BASE  = 21'h00DC00;
  localparam code_t SURR_END       = 21'h00E000;
  localparam code_t SUPP_BASE      = 21'h010000;
  localparam code_t UTF8_2B_BASE   = 21'h000080;
  localparam code_t UTF8_3B_BASE   = 21'h000800;

endpackage

`default_nettype wire

/* hw/rtl/escu_in_if.sv */
// ----------------------------------------------------------------------------
// escu_in_if
// Input channel: one escaped text byte and the count of bytes after it.
// ----------------------------------------------------------------------------
`default_nettype none

interface escu_in_if;
  logic                 valid;
  logic                 ready;
  escu_pkg::byte_t      in_byte;
  escu_pkg::count_t     bytes_after;

  modport source (output valid, output in_byte, output bytes_after, input ready);
  modport sink   (input valid, input in_byte, input bytes_after, output ready);
endinterface

`default_nettype wire

/* hw/rtl/escu_out_if.sv */
// ----------------------------------------------------------------------------
// escu_out_if
// Output channel: one decoded byte and the last-of-item flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface escu_out_if;
  logic                 valid;
  logic                 ready;
  escu_pkg::byte_t      out_byte;
  logic                 run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/escape_sequence_unescaper.sv */
// ----------------------------------------------------------------------------
// escape_sequence_unescaper
// Streaming backslash unescaper with \u (UTF-8, surrogate pairing) and \x.
// ----------------------------------------------------------------------------
// Path: a taken beat is held in the input register, then decoded into the
//   output buffer once that is free, and its first byte is offered at the head.
// Throughput: one input beat per cycle while each yields at most one byte that
//   is taken at once; a multi-byte \u holds the 4-entry buffer till drained.
// Reset: synchronous, active low; empties the input register and output
//   buffer and returns the decoder to plain text with no saved surrogate.
`default_nettype none

module escape_sequence_unescaper (
  input  wire logic  clk,
  input  wire logic  rst_n,
  escu_in_if.sink    in_chan,
  escu_out_if.source out_chan
);

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_UHEX  = 3'd2,
    MODE_XHEX  = 3'd3
  } mode_t;

  // input register
  logic               d_valid_r, d_valid_nxt;
  escu_pkg::byte_t    d_byte_r;
  escu_pkg::count_t   d_after_r;

  // decoder state
  mode_t              mode_r, mode_nxt;
  logic [2:0]         digits_r, digits_nxt;
  escu_pkg::code_t    accum_r, accum_nxt;
  logic [15:0]        saved_r, saved_nxt;

  // output buffer, head at entry 0
  escu_pkg::byte_t    ob_r [4];
  escu_pkg::byte_t    ob_nxt [4];
  logic [2:0]         cnt_r, cnt_nxt;

  // decode results
  escu_pkg::byte_t    res_b [4];
  logic [2:0]         res_n;

  // \u completion path
  escu_pkg::byte_t    dv;
  escu_pkg::code_t    acc_shift;
  escu_pkg::code_t    cp;
  logic               is_high, is_low, do_pair;
  escu_pkg::byte_t    enc_b [4];
  logic [2:0]         enc_n;

  logic               pop, buf_free, fire, load, in_take;

  function automatic escu_pkg::byte_t digit_value(input escu_pkg::byte_t b);
    if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
    if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 8'd10;
    if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 8'd10;
    return b;
  endfunction

  // handshake
  assign pop      = out_chan.valid && out_chan.ready;
  assign buf_free = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && pop);
  assign fire     = d_valid_r && ((res_n == 3'd0) || buf_free);
  assign load     = fire && (res_n != 3'd0);
  assign in_take  = in_chan.valid && in_chan.ready;

  assign in_chan.ready     = !d_valid_r || fire;
  assign out_chan.valid    = cnt_r != 3'd0;
  assign out_chan.out_byte = ob_r[0];
  assign out_chan.run_last = cnt_r == 3'd1;

  assign d_valid_nxt = in_take ? 1'b1 : (fire ? 1'b0 : d_valid_r);

  // hex digit accumulate and \u code point
  assign dv        = digit_value(d_byte_r);
  assign acc_shift = {accum_r[16:0], 4'b0000} + {13'b0, dv};
  assign is_high   = (acc_shift >= escu_pkg::SURR_HIGH_BASE) &&
                     (acc_shift <  escu_pkg::SURR_LOW_BASE);
  assign is_low    = (acc_shift >= escu_pkg::SURR_LOW_BASE) &&
                     (acc_shift <  escu_pkg::SURR_END);
  assign do_pair   = is_low && (saved_r != 16'd0);
  assign cp        = do_pair ? ({1'b0, saved_r[9:0], acc_shift[9:0]} + escu_pkg::SUPP_BASE)
                             : acc_shift;

  // UTF-8 encode
  always_comb begin
    enc_b[0] = cp[7:0];
    enc_b[1] = 8'h00;
    enc_b[2] = 8'h00;
    enc_b[3] = 8'h00;
    enc_n    = 3'd1;
    if (cp < escu_pkg::UTF8_2B_BASE) begin
      enc_b[0] = cp[7:0];
      enc_n    = 3'd1;
    end else if (cp < escu_pkg::UTF8_3B_BASE) begin
      enc_b[0] = {3'b110, cp[10:6]};
      enc_b[1] = {2'b10, cp[5:0]};
      enc_n    = 3'd2;
    end else if (cp < escu_pkg::SUPP_BASE) begin
      enc_b[0] = {4'b1110, cp[15:12]};
      enc_b[1] = {2'b10, cp[11:6]};
      enc_b[2] = {2'b10, cp[5:0]};
      enc_n    = 3'd3;
    end else begin
      enc_b[0] = {5'b11110, cp[20:18]};
      enc_b[1] = {2'b10, cp[17:12]};
      enc_b[2] = {2'b10, cp[11:6]};
      enc_b[3] = {2'b10, cp[5:0]};
      enc_n    = 3'd4;
    end
  end

  // decoder step for the registered beat
  always_comb begin
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    accum_nxt  = accum_r;
    saved_nxt  = saved_r;
    res_n      = 3'd0;
    res_b[0]   = d_byte_r;
    res_b[1]   = enc_b[1];
    res_b[2]   = enc_b[2];
    res_b[3]   = enc_b[3];
    case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_PLAIN;
        if (d_byte_r == escu_pkg::CH_U && d_after_r >= escu_pkg::U_MIN_AFTER) begin
          mode_nxt   = MODE_UHEX;
          digits_nxt = escu_pkg::U_DIGITS;
          accum_nxt  = '0;
        end else if (d_byte_r == escu_pkg::CH_X && d_after_r >= escu_pkg::X_MIN_AFTER) begin
          mode_nxt   = MODE_XHEX;
          digits_nxt = escu_pkg::X_DIGITS;
          accum_nxt  = '0;
        end else begin
          saved_nxt = 16'd0;
          res_n     = 3'd1;
          case (d_byte_r)
            escu_pkg::CH_B: res_b[0] = escu_pkg::OUT_BS;
            escu_pkg::CH_T: res_b[0] = escu_pkg::OUT_TAB;
            escu_pkg::CH_N: res_b[0] = escu_pkg::OUT_LF;
            escu_pkg::CH_R: res_b[0] = escu_pkg::OUT_CR;
            escu_pkg::CH_F: res_b[0] = escu_pkg::OUT_FF;
            escu_pkg::CH_S: res_b[0] = escu_pkg::OUT_SPACE;
            default:        res_b[0] = d_byte_r;
          endcase
        end
      end
      MODE_UHEX: begin
        accum_nxt  = acc_shift;
        digits_nxt = digits_r - 3'd1;
        if (digits_r == 3'd1) begin
          mode_nxt  = MODE_PLAIN;
          accum_nxt = '0;
          if (is_high) begin
            saved_nxt = acc_shift[15:0];
          end else begin
            if (do_pair) saved_nxt = 16'd0;
            res_n    = enc_n;
            res_b[0] = enc_b[0];
          end
        end
      end
      MODE_XHEX: begin
        accum_nxt  = {13'b0, acc_shift[7:0]};
        digits_nxt = digits_r - 3'd1;
        if (digits_r == 3'd1) begin
          mode_nxt  = MODE_PLAIN;
          accum_nxt = '0;
          res_n     = 3'd1;
          res_b[0]  = acc_shift[7:0];
        end
      end
      default: begin
        mode_nxt = MODE_PLAIN;
        if (d_byte_r == escu_pkg::CH_BSLASH && d_after_r != 16'd0) begin
          mode_nxt = MODE_ESC;
        end else begin
          saved_nxt = 16'd0;
          res_n     = 3'd1;
        end
      end
    endcase
    // end of string: everything back to reset, unfinished escape dropped
    if (d_after_r == 16'd0) begin
      mode_nxt   = MODE_PLAIN;
      digits_nxt = 3'd0;
      accum_nxt  = '0;
      saved_nxt  = 16'd0;
    end
  end

  // output buffer
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < 4; i++) ob_nxt[i] = ob_r[i];
    if (load) begin
      cnt_nxt = res_n;
      for (int i = 0; i < 4; i++) ob_nxt[i] = res_b[i];
    end else if (pop) begin
      cnt_nxt = cnt_r - 3'd1;
      for (int i = 0; i < 3; i++) ob_nxt[i] = ob_r[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      cnt_r     <= 3'd0;
      mode_r    <= MODE_PLAIN;
      digits_r  <= 3'd0;
      accum_r   <= '0;
      saved_r   <= 16'd0;
    end else begin
      d_valid_r <= d_valid_nxt;
      cnt_r     <= cnt_nxt;
      if (fire) begin
        mode_r   <= mode_nxt;
        digits_r <= digits_nxt;
        accum_r  <= accum_nxt;
        saved_r  <= saved_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      d_byte_r  <= in_chan.in_byte;
      d_after_r <= in_chan.bytes_after;
    end
    for (int i = 0; i < 4; i++) ob_r[i] <= ob_nxt[i];
  end

  // ---------------------------------------------------------------------------
  // assertions
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && d_after_r == 16'd0) |=>
      (mode_r == MODE_PLAIN && saved_r == 16'd0 && accum_r == '0))
    else $error("state not cleared after last beat of string");

  a_digits_live: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_UHEX || mode_r == MODE_XHEX) |-> (digits_r != 3'd0))
    else $error("hex mode with no digits left");

  a_saved_high: assert property (@(posedge clk) disable iff (!rst_n)
    (saved_r == 16'd0) || (saved_r[15:10] == 6'b110110))
    else $error("saved surrogate outside high range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > 3'd1 && !pop) |=> (cnt_r == $past(cnt_r)))
    else $error("output buffer overwritten while bytes pending");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks escape_sequence_unescaper against a behavioral decoder kept in the
// bench. Directed strings cover plain bytes, simple, \x and \u escapes,
// surrogate pairing and short escapes; random strings of escape tokens follow
// under three idle mixes on the input and output channels.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic [2:0] {DEC_PLAIN, DEC_ESC, DEC_UHEX, DEC_XHEX} dec_mode_t;
  typedef struct packed {
    escu_pkg::byte_t data;
    logic            last;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  escu_in_if  in_chan ();
  escu_out_if out_chan ();

  escape_sequence_unescaper uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // decoder state mirrored in the bench
  dec_mode_t         dec_mode;
  logic [2:0]        dec_digits;
  escu_pkg::code_t   dec_accum;
  logic [15:0]       dec_saved_hi;

  out_beat_t expected_bytes[$];
  int        mismatch_count;
  int        tx_idle_pct;
  int        rx_idle_pct;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function void clear_decoder();
    dec_mode     = DEC_PLAIN;
    dec_digits   = '0;
    dec_accum    = '0;
    dec_saved_hi = '0;
  endfunction

  // Advance the decoder by one accepted beat and queue the bytes it yields.
  task automatic decode_beat(input escu_pkg::byte_t b, input escu_pkg::count_t after);
    escu_pkg::byte_t outs[4];
    int              n;
    escu_pkg::byte_t dv;
    escu_pkg::byte_t xb;
    escu_pkg::code_t cp;
    n = 0;
    // non-hex bytes count with their raw value
    if (b >= "0" && b <= "9") dv = b - "0";
    else if (b >= "a" && b <= "f") dv = b - "a" + 8'd10;
    else if (b >= "A" && b <= "F") dv = b - "A" + 8'd10;
    else dv = b;

    case (dec_mode)
      DEC_ESC: begin
        dec_mode = DEC_PLAIN;
        if (b == escu_pkg::CH_U && after >= escu_pkg::U_MIN_AFTER) begin
          dec_mode   = DEC_UHEX;
          dec_digits = escu_pkg::U_DIGITS;
          dec_accum  = '0;
        end else if (b == escu_pkg::CH_X && after >= escu_pkg::X_MIN_AFTER) begin
          dec_mode   = DEC_XHEX;
          dec_digits = escu_pkg::X_DIGITS;
          dec_accum  = '0;
        end else begin
          dec_saved_hi = '0;
          case (b)
            escu_pkg::CH_B: outs[0] = escu_pkg::OUT_BS;
            escu_pkg::CH_T: outs[0] = escu_pkg::OUT_TAB;
            escu_pkg::CH_N: outs[0] = escu_pkg::OUT_LF;
            escu_pkg::CH_R: outs[0] = escu_pkg::OUT_CR;
            escu_pkg::CH_F: outs[0] = escu_pkg::OUT_FF;
            escu_pkg::CH_S: outs[0] = escu_pkg::OUT_SPACE;
            default:        outs[0] = b;
          endcase
          n = 1;
        end
      end
      DEC_UHEX: begin
        dec_accum  = (dec_accum << 4) + escu_pkg::code_t'(dv);
        dec_digits = dec_digits - 3'd1;
        if (dec_digits == 3'd0) begin
          dec_mode  = DEC_PLAIN;
          cp        = dec_accum;
          dec_accum = '0;
          if (cp >= escu_pkg::SURR_HIGH_BASE && cp < escu_pkg::SURR_LOW_BASE) begin
            dec_saved_hi = cp[15:0];
          end else begin
            if (cp >= escu_pkg::SURR_LOW_BASE && cp < escu_pkg::SURR_END &&
                dec_saved_hi != '0) begin
              cp = (((escu_pkg::code_t'(dec_saved_hi) - escu_pkg::SURR_HIGH_BASE) << 10) |
                    (cp - escu_pkg::SURR_LOW_BASE)) + escu_pkg::SUPP_BASE;
              dec_saved_hi = '0;
            end
            if (cp < escu_pkg::UTF8_2B_BASE) begin
              outs[0] = cp[7:0];
              n = 1;
            end else if (cp < escu_pkg::UTF8_3B_BASE) begin
              outs[0] = {3'b110, cp[10:6]};
              outs[1] = {2'b10, cp[5:0]};
              n = 2;
            end else if (cp < escu_pkg::SUPP_BASE) begin
              outs[0] = {4'b1110, cp[15:12]};
              outs[1] = {2'b10, cp[11:6]};
              outs[2] = {2'b10, cp[5:0]};
              n = 3;
            end else begin
              outs[0] = {5'b11110, cp[20:18]};
              outs[1] = {2'b10, cp[17:12]};
              outs[2] = {2'b10, cp[11:6]};
              outs[3] = {2'b10, cp[5:0]};
              n = 4;
            end
          end
        end
      end
      DEC_XHEX: begin
        xb         = {dec_accum[3:0], 4'h0} + dv;
        dec_accum  = escu_pkg::code_t'(xb);
        dec_digits = dec_digits - 3'd1;
        if (dec_digits == 3'd0) begin
          dec_mode  = DEC_PLAIN;
          dec_accum = '0;
          outs[0]   = xb;
          n = 1;
        end
      end
      default: begin
        dec_mode = DEC_PLAIN;
        if (b == escu_pkg::CH_BSLASH && after != '0) begin
          dec_mode = DEC_ESC;
        end else begin
          dec_saved_hi = '0;
          outs[0] = b;
          n = 1;
        end
      end
    endcase

    for (int i = 0; i < n; i++) expected_bytes.push_back(out_beat_t'{outs[i], (i == n - 1)});
    if (after == '0) clear_decoder();
  endtask

  task automatic send_item(input escu_pkg::byte_t b, input escu_pkg::count_t after);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.in_byte     <= b;
    in_chan.bytes_after <= after;
    do @(posedge clk); while (!in_chan.ready);
    decode_beat(b, after);
  endtask

  // Counts are exact, or padded to no less than the true remainder (last stays zero).
  task automatic send_text(input escu_pkg::byte_t text[$], input bit padded);
    escu_pkg::count_t after;
    int               left;
    foreach (text[i]) begin
      left  = text.size() - 1 - i;
      after = escu_pkg::count_t'(left);
      if (padded && left != 0)
        after = escu_pkg::count_t'(left + $urandom_range(65535 - left));
      send_item(text[i], after);
    end
  endtask

  task automatic send_string(input string s);
    escu_pkg::byte_t text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(text, 1'b0);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic escu_pkg::byte_t digit_char(input logic [3:0] v);
    if ($urandom_range(99) < 8) return escu_pkg::byte_t'($urandom);
    if (v < 4'd10) return escu_pkg::byte_t'("0" + v);
    return escu_pkg::byte_t'(($urandom_range(1) ? "a" : "A") + v - 8'd10);
  endfunction

  task automatic add_unicode(ref escu_pkg::byte_t text[$], input logic [15:0] cp);
    text.push_back(escu_pkg::CH_BSLASH);
    text.push_back(escu_pkg::CH_U);
    for (int k = 3; k >= 0; k--) text.push_back(digit_char(cp[k*4 +: 4]));
  endtask

  task automatic add_token(ref escu_pkg::byte_t text[$]);
    int          pick;
    logic [15:0] hi;
    logic [15:0] lo;
    pick = $urandom_range(99);
    hi   = 16'(escu_pkg::SURR_HIGH_BASE) + 16'($urandom_range(16'h3FF));
    lo   = 16'(escu_pkg::SURR_LOW_BASE) + 16'($urandom_range(16'h3FF));
    if (pick < 30) begin
      text.push_back(escu_pkg::byte_t'($urandom));
    end else if (pick < 50) begin
      text.push_back(escu_pkg::CH_BSLASH);
      case ($urandom_range(7))
        0:       text.push_back(escu_pkg::CH_B);
        1:       text.push_back(escu_pkg::CH_T);
        2:       text.push_back(escu_pkg::CH_N);
        3:       text.push_back(escu_pkg::CH_R);
        4:       text.push_back(escu_pkg::CH_F);
        5:       text.push_back(escu_pkg::CH_S);
        6:       text.push_back(escu_pkg::CH_BSLASH);
        default: text.push_back(escu_pkg::byte_t'($urandom));
      endcase
    end else if (pick < 65) begin
      text.push_back(escu_pkg::CH_BSLASH);
      text.push_back(escu_pkg::CH_X);
      text.push_back(digit_char(4'($urandom)));
      text.push_back(digit_char(4'($urandom)));
    end else if (pick < 75) begin
      // vary magnitude so 1, 2 and 3 byte encodings all show up
      add_unicode(text, 16'($urandom) >> $urandom_range(15));
    end else if (pick < 90) begin
      add_unicode(text, hi);
      add_unicode(text, lo);
    end else if (pick < 95) begin
      add_unicode(text, hi);
    end else begin
      add_unicode(text, lo);
    end
  endtask

  task automatic test_plain_bytes();
    send_item(8'h00, 16'hFFFF);
    send_item(8'hFF, 16'd1);
    send_item(escu_pkg::CH_BSLASH, 16'd0);  // backslash at end of string is literal
    wait_drain();
  endtask

  task automatic test_simple_escapes();
    send_string("\\s\\q");
    wait_drain();
  endtask

  task automatic test_hex_byte();
    send_string("\\xFf");
    wait_drain();
  endtask

  task automatic test_surrogate_pair();
    send_string("\\uD83D\\uDE00");
    wait_drain();
  endtask

  task automatic test_short_escape();
    send_string("\\x1");
    wait_drain();
  endtask

  task automatic test_random_text(input int tx_pct, input int rx_pct, input int n_items);
    escu_pkg::byte_t text[$];
    int              sent;
    int              n_tokens;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      text.delete();
      n_tokens = $urandom_range(6, 1);
      repeat (n_tokens) add_token(text);
      // cut some strings short to leave escapes unfinished
      if ($urandom_range(99) < 15) text = text[0 : $urandom_range(text.size() - 1)];
      sent += text.size();
      send_text(text, $urandom_range(99) < 25);
    end
    wait_drain();
  endtask

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : check_output
    out_beat_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, actual out_byte %02h run_last %b",
                 $time, out_chan.out_byte, out_chan.run_last);
      end else begin
        want = expected_bytes.pop_front();
        if (out_chan.out_byte !== want.data) begin
          mismatch_count++;
          $display("%0t: out_byte expected %02h actual %02h",
                   $time, want.data, out_chan.out_byte);
        end
        if (out_chan.run_last !== want.last) begin
          mismatch_count++;
          $display("%0t: run_last expected %b actual %b",
                   $time, want.last, out_chan.run_last);
        end
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.in_byte     = '0;
    in_chan.bytes_after = '0;
    out_chan.ready      = 1'b0;
    mismatch_count      = 0;
    tx_idle_pct         = 13;
    rx_idle_pct         = 65;
    clear_decoder();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_bytes();
    test_simple_escapes();
    test_hex_byte();
    test_surrogate_pair();
    test_short_escape();
    test_random_text(13, 65, 130);
    test_random_text(65, 13, 130);
    test_random_text(0, 0, 130);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/escu_pkg.sv
hw/rtl/escu_in_if.sv
hw/rtl/escu_out_if.sv
hw/rtl/escape_sequence_unescaper.sv
tb/testbench.sv
